/* rtl/core/serial_command_frame_parser_macros.svh */
// ----------------------------------------------------------------------------
// Serial command frame parser assertion macros
// Shared property forms for the frame parser checks. They expect clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH

// Same-cycle implication
`define SCFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SCFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/scfp_pkg.sv */
// ----------------------------------------------------------------------------
// Frame parser package
// Frame markers, command codes, length and reset constants, result status codes and shared types.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam logic [7:0] START_BYTE    = 8'hA0;
    localparam logic [7:0] END_BYTE      = 8'hA1;
    localparam logic [7:0] CMD_FORWARD   = 8'hF1;
    localparam logic [7:0] CMD_SET_COUNT = 8'hF2;
    localparam int unsigned MIN_HELD     = 5;
    localparam logic [7:0] POLL_RESET    = 8'd30;

    typedef enum logic [2:0] {
        ST_INCOMPLETE = 3'd0,
        ST_COUNT_SET  = 3'd1,
        ST_FORWARD    = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_BAD_SUM    = 3'd4,
        ST_BAD_START  = 3'd5,
        ST_OVERFLOW   = 3'd6,
        ST_NODE_SET   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SUM,
        S_DRAIN,
        S_CHECK,
        S_FWD_RD,
        S_FWD_WR
    } state_t;

    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctl_t;

endpackage

/* rtl/core/scfp_in_if.sv */
// ----------------------------------------------------------------------------
// Frame parser input channel
// Valid/ready channel carrying one received serial byte per item.
// ----------------------------------------------------------------------------
interface scfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/scfp_out_if.sv */
// ----------------------------------------------------------------------------
// Frame parser result channel
// Valid/ready channel carrying one parser result per item.
// ----------------------------------------------------------------------------
interface scfp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] fwd_byte;
    logic       last;
    logic       led_ok;
    logic [7:0] poll_count_out;
    logic [7:0] node_address_out;

    modport source (output valid, output status, output fwd_byte, output last,
                    output led_ok, output poll_count_out, output node_address_out,
                    input ready);
    modport sink   (input valid, input status, input fwd_byte, input last,
                    input led_ok, input poll_count_out, input node_address_out,
                    output ready);
endinterface

/* rtl/core/scfp_store.sv */
// ----------------------------------------------------------------------------
// Frame store
// Dual-port byte memory (one write port, one read port) holding the frame under assembly, registered read.
// ----------------------------------------------------------------------------
module scfp_store
    import scfp_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [7:0]       wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [7:0]       rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/scfp_acc.sv */
// ----------------------------------------------------------------------------
// Checksum accumulator
// Shared 8-bit adder that sums frame bytes one per cycle and compares the
// total against the received checksum.
// ----------------------------------------------------------------------------
module scfp_acc
    import scfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  acc_ctl_t   ctl,
    input  logic [7:0] data,
    input  logic [7:0] chk,
    output logic       match
);

    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            sum_next = 8'd0;
        end
        else if (ctl.add)
        begin
            sum_next = sum_reg + data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'd0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign match = (sum_reg == chk);

endmodule

/* rtl/core/serial_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// Serial command frame parser
// Collects serial bytes into frames, checks them and executes commands.
// ----------------------------------------------------------------------------
// Each accepted byte is written to a dual-port frame store. A byte that
// does not complete a frame gives one result, loaded from S_EMIT when the
// output register is free. A completed gateway frame of n bytes is summed
// by one 8-bit adder walking the frame store one byte per cycle; a forward
// command then sends the frame out byte by byte (store read, then result
// load, which waits while the output register is full). The input is not
// ready while a byte is being handled. A held result in the output
// register does not block taking the next byte. Node-mode frames take
// the address from byte 1 with no checksum walk.
// ----------------------------------------------------------------------------
`include "serial_command_frame_parser_macros.svh"

module serial_command_frame_parser
    import scfp_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    scfp_in_if.sink     in_ch,
    scfp_out_if.source  out_ch
);

    localparam int unsigned IDX_W = $clog2(FRAME_MAX);
    localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             mode_reg, mode_next;
    logic [7:0]       poll_reg, poll_next;
    logic [7:0]       node_reg, node_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             ov_reg, ov_next;

    logic [7:0]       byte0_reg, byte0_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       arg_reg, arg_next;
    logic [7:0]       prev_reg, prev_next;
    logic [7:0]       chk_reg, chk_next;
    status_t          res_reg, res_next;
    logic             res_ok_reg, res_ok_next;
    status_t          ost_reg, ost_next;
    logic [7:0]       ofwd_reg, ofwd_next;
    logic             olast_reg, olast_next;
    logic             ook_reg, ook_next;
    logic [7:0]       opoll_reg, opoll_next;
    logic [7:0]       onode_reg, onode_next;

    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;
    acc_ctl_t         acc_ctl;
    logic             acc_match;

    logic             out_free;
    logic [7:0]       byte0_v;
    logic [CNT_W-1:0] n_v;
    logic             complete_v;
    logic             fwd_last;

    scfp_store #(
        .DEPTH (FRAME_MAX)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (fill_reg),
        .wdata (in_ch.rx_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    scfp_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (acc_ctl),
        .data  (mem_rdata),
        .chk   (chk_reg),
        .match (acc_match)
    );

    assign out_free = !ov_reg || out_ch.ready;
    assign byte0_v  = (fill_reg == '0) ? in_ch.rx_byte : byte0_reg;
    assign n_v      = CNT_W'(fill_reg) + CNT_W'(1);
    assign complete_v = (n_v > CNT_W'(MIN_HELD)) && (byte0_v == START_BYTE) &&
                        (in_ch.rx_byte == END_BYTE);
    assign fwd_last = (CNT_W'(cnt_reg) == n_reg - CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        mode_next   = cfg_we ? cfg_wdata : mode_reg;
        poll_next   = poll_reg;
        node_next   = node_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        ov_next     = ov_reg;
        byte0_next  = byte0_reg;
        cmd_next    = cmd_reg;
        arg_next    = arg_reg;
        prev_next   = prev_reg;
        chk_next    = chk_reg;
        res_next    = res_reg;
        res_ok_next = res_ok_reg;
        ost_next    = ost_reg;
        ofwd_next   = ofwd_reg;
        olast_next  = olast_reg;
        ook_next    = ook_reg;
        opoll_next  = opoll_reg;
        onode_next  = onode_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = cnt_reg;
        in_ch.ready = (state_reg == S_IDLE);

        // Skip the checksum byte itself while summing
        acc_ctl.clear = 1'b0;
        acc_ctl.add   = rd_vld_reg && (CNT_W'(rd_idx_reg) != n_reg - CNT_W'(2));

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mem_we        = 1'b1;
                    acc_ctl.clear = 1'b1;
                    prev_next     = in_ch.rx_byte;
                    chk_next      = prev_reg;
                    n_next        = n_v;
                    res_ok_next   = 1'b0;
                    state_next    = S_EMIT;
                    if (fill_reg == IDX_W'(0))
                    begin
                        byte0_next = in_ch.rx_byte;
                    end
                    if (fill_reg == IDX_W'(1))
                    begin
                        cmd_next = in_ch.rx_byte;
                    end
                    if (fill_reg == IDX_W'(2))
                    begin
                        arg_next = in_ch.rx_byte;
                    end

                    if (complete_v && mode_reg)
                    begin
                        fill_next  = '0;
                        cnt_next   = '0;
                        state_next = S_SUM;
                    end
                    else if (complete_v)
                    begin
                        node_next = cmd_reg;
                        res_next  = ST_NODE_SET;
                        fill_next = (n_v == CNT_W'(FRAME_MAX)) ? '0 : IDX_W'(n_v);
                    end
                    else if (byte0_v != START_BYTE)
                    begin
                        fill_next = '0;
                        res_next  = ST_BAD_START;
                    end
                    else if (n_v == CNT_W'(FRAME_MAX))
                    begin
                        fill_next = '0;
                        res_next  = ST_OVERFLOW;
                    end
                    else
                    begin
                        fill_next = IDX_W'(n_v);
                        res_next  = ST_INCOMPLETE;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_reg;
                    ofwd_next  = 8'd0;
                    olast_next = 1'b1;
                    ook_next   = res_ok_reg;
                    opoll_next = poll_reg;
                    onode_next = node_reg;
                    state_next = S_IDLE;
                end
            end

            S_SUM:
            begin
                mem_re      = 1'b1;
                rd_vld_next = 1'b1;
                rd_idx_next = cnt_reg;
                if (fwd_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            S_DRAIN:
            begin
                // last read lands in the accumulator this cycle
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                state_next = S_EMIT;
                if (!acc_match)
                begin
                    res_next = ST_BAD_SUM;
                end
                else
                begin
                    res_ok_next = 1'b1;
                    if (cmd_reg == CMD_SET_COUNT)
                    begin
                        poll_next = arg_reg;
                        res_next  = ST_COUNT_SET;
                    end
                    else if (cmd_reg == CMD_FORWARD)
                    begin
                        cnt_next   = '0;
                        state_next = S_FWD_RD;
                    end
                    else
                    begin
                        res_next = ST_UNKNOWN;
                    end
                end
            end

            S_FWD_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_FWD_WR;
            end

            S_FWD_WR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_FORWARD;
                    ofwd_next  = mem_rdata;
                    olast_next = fwd_last;
                    ook_next   = 1'b1;
                    opoll_next = poll_reg;
                    onode_next = node_reg;
                    if (fwd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = S_FWD_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            n_reg      <= '0;
            cnt_reg    <= '0;
            mode_reg   <= 1'b1;
            poll_reg   <= POLL_RESET;
            node_reg   <= 8'd0;
            rd_vld_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            n_reg      <= n_next;
            cnt_reg    <= cnt_next;
            mode_reg   <= mode_next;
            poll_reg   <= poll_next;
            node_reg   <= node_next;
            rd_vld_reg <= rd_vld_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        byte0_reg  <= byte0_next;
        cmd_reg    <= cmd_next;
        arg_reg    <= arg_next;
        prev_reg   <= prev_next;
        chk_reg    <= chk_next;
        res_reg    <= res_next;
        res_ok_reg <= res_ok_next;
        ost_reg    <= ost_next;
        ofwd_reg   <= ofwd_next;
        olast_reg  <= olast_next;
        ook_reg    <= ook_next;
        opoll_reg  <= opoll_next;
        onode_reg  <= onode_next;
    end

    assign out_ch.valid            = ov_reg;
    assign out_ch.status           = ost_reg;
    assign out_ch.fwd_byte         = ofwd_reg;
    assign out_ch.last             = olast_reg;
    assign out_ch.led_ok           = ook_reg;
    assign out_ch.poll_count_out   = opoll_reg;
    assign out_ch.node_address_out = onode_reg;

    `SCFP_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while a byte is in work")
    `SCFP_ASSERT_IMP(a_fwd_byte_zero, out_ch.valid && (out_ch.status != ST_FORWARD), out_ch.fwd_byte == 8'd0, "nonzero byte on a non-forward result")
    `SCFP_ASSERT_IMP(a_multi_only_fwd, out_ch.valid && !out_ch.last, out_ch.status == ST_FORWARD, "open result that is not a forwarded byte")
    `SCFP_ASSERT_IMP(a_walk_in_frame, state_reg == S_SUM, CNT_W'(cnt_reg) < n_reg, "checksum walk past frame end")
    `SCFP_ASSERT_NXT(a_check_clears_fill, state_reg == S_CHECK, fill_reg == '0, "store not cleared after gateway frame")

endmodule
